/* design/iet_pkg.sv */
package iet_pkg;

	// Frame limits
	localparam logic [15:0] MAX_FRAME_BYTES = 16'd65535;

	// IPv4 header layout
	localparam logic [3:0]  IP_VERSION   = 4'd4;
	localparam logic [5:0]  IP_MIN_HDR   = 6'd20;
	localparam logic [15:0] POS_PROTOCOL = 16'd9;
	localparam logic [15:0] POS_SRC_FIRST = 16'd12;
	localparam logic [15:0] POS_SRC_LAST  = 16'd15;
	localparam logic [7:0]  PROTO_ICMP   = 8'd1;

	// ICMP header and session id layout, offsets from the ICMP start
	localparam logic [15:0] REL_TYPE      = 16'd0;
	localparam logic [15:0] REL_ID_HIGH   = 16'd4;
	localparam logic [15:0] REL_ID_LOW    = 16'd5;
	localparam logic [15:0] ICMP_LEN      = 16'd8;
	localparam logic [15:0] SID_LEN       = 16'd8;
	localparam logic [15:0] PAYLOAD_START = ICMP_LEN + SID_LEN;
	localparam logic [7:0]  TYPE_REQUEST  = 8'd8;
	localparam logic [7:0]  TYPE_REPLY    = 8'd0;

	// Verdict codes
	localparam logic [2:0] VERDICT_ACCEPT     = 3'd0;
	localparam logic [2:0] VERDICT_MALFORMED  = 3'd1;
	localparam logic [2:0] VERDICT_NOT_ICMP   = 3'd2;
	localparam logic [2:0] VERDICT_WRONG_TYPE = 3'd3;
	localparam logic [2:0] VERDICT_WRONG_ID   = 3'd4;
	localparam logic [2:0] VERDICT_TOO_LONG   = 3'd5;

	// Configuration register indexes
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam logic [CFG_INDEX_W-1:0] REG_SERVER_MODE   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TUNNEL_ID     = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_CAP   = 2'd2;

	// Result payload, lowest field last so payload_byte sits in bits 7:0
	typedef struct packed {
		logic [3:0]  pad;
		logic        peer_updated;
		logic [15:0] payload_len;
		logic [31:0] source_addr;
		logic [63:0] session_id;
		logic [2:0]  verdict;
		logic [7:0]  payload_byte;
	} result_t;

endpackage

/* design/icmp_echo_tunnel_deframer_unit.sv */
// ICMP echo tunnel deframer.
// Input stream (s_axis_*): one byte of a received IPv4 frame per item, tlast on
// the frame's final byte. The header is checked as it streams: version, IHL,
// protocol ICMP, echo type allowed by server_mode, identifier. The 8 bytes
// after the ICMP header form the session id; later bytes are payload.
// Output stream (m_axis_*): an item for every passed payload byte (tuser = 1)
// and one for the last byte of every frame (tlast = 1) carrying the verdict,
// session id, source address, payload length and peer update flag. Payload
// already passed of a rejected frame is to be discarded downstream.
// Latency: the result appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle; all per-byte work lies between the frame
// state registers and the single output register.
// Stall: while an output item waits and m_axis_tready is low, s_axis_tready
// is low; otherwise a new byte is taken every cycle, also while the waiting
// item leaves.
// Reset: frame state, peer and registers return to defaults (server_mode 0,
// tunnel_identifier 0, payload_capacity 65535); no output item is pending.
// Configuration: cfg_we writes cfg_data to register cfg_index.
module icmp_echo_tunnel_deframer_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration
	input  logic                                  cfg_we,
	input  logic [iet_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [iet_pkg::CFG_DATA_W-1:0]        cfg_data,
	// frame bytes in
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [7:0]                            s_axis_tdata,   // data_byte
	input  logic                                  s_axis_tlast,   // last_byte
	// results out
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// payload_byte[7:0], verdict[10:8], session_id[74:11], source_addr[106:75],
	// payload_len[122:107], peer_updated[123], zero[127:124]
	output logic [127:0]                          m_axis_tdata,
	output logic                                  m_axis_tuser,   // byte_valid
	output logic                                  m_axis_tlast    // frame_end
);

	// configuration registers
	logic        server_mode_q;
	logic [15:0] tunnel_id_q;
	logic [15:0] payload_cap_q;

	// frame state
	logic [15:0] pos_q;
	logic [5:0]  hdr_q;
	logic [2:0]  drop_q;
	logic [7:0]  id_high_q;
	logic [63:0] sess_q;
	logic [31:0] src_q;
	logic        peer_valid_q;
	logic [31:0] peer_q;

	// output register
	logic                 out_valid_q;
	logic                 out_byte_valid_q;
	logic                 out_last_q;
	iet_pkg::result_t     out_q;

	// per-byte logic
	logic        accept;
	logic [7:0]  b;
	logic        oversize;
	logic [5:0]  hdr_n;
	logic [15:0] hdr_ext;
	logic [2:0]  drop_a;
	logic [2:0]  drop_n;
	logic [7:0]  id_high_n;
	logic [63:0] sess_n;
	logic [31:0] src_n;
	logic [15:0] pos_n;
	logic [15:0] rel;
	logic [15:0] pay_idx;
	logic        in_icmp;
	logic        pass;
	logic        emit;
	logic [16:0] n_bytes;
	logic        short_frame;
	logic [16:0] plen_full;
	logic [15:0] plen;
	logic [2:0]  verdict;
	logic        learn;
	iet_pkg::result_t res;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign b             = s_axis_tdata;

	// Check one byte against the frame state
	always_comb begin
		oversize  = pos_q >= iet_pkg::MAX_FRAME_BYTES;
		hdr_n     = (pos_q == 16'd0) ? {b[3:0], 2'b00} : hdr_q;
		hdr_ext   = {10'd0, hdr_n};
		drop_a    = drop_q;
		if (oversize) begin
			drop_a = iet_pkg::VERDICT_MALFORMED;
		end else if (pos_q == 16'd0 &&
			(b[7:4] != iet_pkg::IP_VERSION || hdr_n < iet_pkg::IP_MIN_HDR)) begin
			drop_a = iet_pkg::VERDICT_MALFORMED;
		end

		rel       = pos_q - hdr_ext;
		pay_idx   = rel - iet_pkg::PAYLOAD_START;
		in_icmp   = (pos_q >= hdr_ext) && (hdr_n >= iet_pkg::IP_MIN_HDR);
		drop_n    = drop_a;
		id_high_n = id_high_q;
		sess_n    = sess_q;
		pass      = 1'b0;
		if (!oversize && drop_a == iet_pkg::VERDICT_ACCEPT) begin
			if (pos_q == iet_pkg::POS_PROTOCOL && b != iet_pkg::PROTO_ICMP) begin
				drop_n = iet_pkg::VERDICT_NOT_ICMP;
			end else if (in_icmp) begin
				if (rel == iet_pkg::REL_TYPE) begin
					if (!(b == iet_pkg::TYPE_REQUEST ||
						(!server_mode_q && b == iet_pkg::TYPE_REPLY))) begin
						drop_n = iet_pkg::VERDICT_WRONG_TYPE;
					end
				end else if (rel == iet_pkg::REL_ID_HIGH) begin
					id_high_n = b;
				end else if (rel == iet_pkg::REL_ID_LOW) begin
					if ({id_high_q, b} != tunnel_id_q) begin
						drop_n = iet_pkg::VERDICT_WRONG_ID;
					end
				end else if (rel >= iet_pkg::ICMP_LEN && rel < iet_pkg::PAYLOAD_START) begin
					sess_n = {sess_q[55:0], b};
				end else if (rel >= iet_pkg::PAYLOAD_START) begin
					pass = pay_idx < payload_cap_q;
				end
			end
		end

		src_n = src_q;
		if (!oversize && pos_q >= iet_pkg::POS_SRC_FIRST && pos_q <= iet_pkg::POS_SRC_LAST) begin
			src_n = {src_q[23:0], b};
		end
		pos_n = oversize ? pos_q : pos_q + 16'd1;
	end

	// Form the verdict on the last byte
	always_comb begin
		n_bytes     = {1'b0, pos_q} + 17'd1;
		short_frame = (n_bytes < {11'd0, iet_pkg::IP_MIN_HDR}) ||
			(n_bytes < {11'd0, hdr_n} + {1'b0, iet_pkg::PAYLOAD_START});
		plen_full   = n_bytes - {11'd0, hdr_n} - {1'b0, iet_pkg::PAYLOAD_START};
		plen        = plen_full[15:0];
		if (drop_n == iet_pkg::VERDICT_MALFORMED || short_frame) begin
			verdict = iet_pkg::VERDICT_MALFORMED;
		end else if (drop_n != iet_pkg::VERDICT_ACCEPT) begin
			verdict = drop_n;
		end else if (plen > payload_cap_q) begin
			verdict = iet_pkg::VERDICT_TOO_LONG;
		end else begin
			verdict = iet_pkg::VERDICT_ACCEPT;
		end
		learn = s_axis_tlast && verdict == iet_pkg::VERDICT_ACCEPT && server_mode_q &&
			(!peer_valid_q || peer_q != src_n);
		emit  = pass || s_axis_tlast;

		res              = '0;
		res.payload_byte = pass ? b : 8'd0;
		if (s_axis_tlast) begin
			res.verdict      = verdict;
			res.peer_updated = learn;
			if (verdict == iet_pkg::VERDICT_ACCEPT) begin
				res.session_id  = sess_n;
				res.source_addr = src_n;
				res.payload_len = plen;
			end
		end
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_mode_q <= 1'b0;
			tunnel_id_q   <= 16'd0;
			payload_cap_q <= 16'hFFFF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				iet_pkg::REG_SERVER_MODE: server_mode_q <= cfg_data[0];
				iet_pkg::REG_TUNNEL_ID:   tunnel_id_q   <= cfg_data;
				iet_pkg::REG_PAYLOAD_CAP: payload_cap_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance frame state; clear it after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= 16'd0;
			hdr_q        <= 6'd0;
			drop_q       <= iet_pkg::VERDICT_ACCEPT;
			id_high_q    <= 8'd0;
			sess_q       <= 64'd0;
			src_q        <= 32'd0;
			peer_valid_q <= 1'b0;
			peer_q       <= 32'd0;
		end else if (accept) begin
			if (s_axis_tlast) begin
				pos_q     <= 16'd0;
				hdr_q     <= 6'd0;
				drop_q    <= iet_pkg::VERDICT_ACCEPT;
				id_high_q <= 8'd0;
				sess_q    <= 64'd0;
				src_q     <= 32'd0;
			end else begin
				pos_q     <= pos_n;
				hdr_q     <= hdr_n;
				drop_q    <= drop_n;
				id_high_q <= id_high_n;
				sess_q    <= sess_n;
				src_q     <= src_n;
			end
			if (learn) begin
				peer_valid_q <= 1'b1;
				peer_q       <= src_n;
			end
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= emit;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			out_q            <= res;
			out_byte_valid_q <= pass;
			out_last_q       <= s_axis_tlast;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;
	assign m_axis_tuser  = out_byte_valid_q;
	assign m_axis_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
	// A result is either a passed payload byte or a frame end
	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser || m_axis_tlast))
		else $error("result item is neither payload nor frame end");

	// Verdict and peer flag stay zero on plain payload items
	a_mid_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tlast) |->
		(out_q.verdict == iet_pkg::VERDICT_ACCEPT && !out_q.peer_updated))
		else $error("verdict fields set on a mid-frame item");

	// A peer is learned only on an accepted frame
	a_learn_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && out_q.peer_updated) |->
		(m_axis_tlast && out_q.verdict == iet_pkg::VERDICT_ACCEPT))
		else $error("peer learned on a rejected frame");

	// Frame state restarts after the last byte
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_axis_tlast) |=> (pos_q == 16'd0 && drop_q == iet_pkg::VERDICT_ACCEPT))
		else $error("frame state not cleared after last byte");

	// Byte position never runs past the frame limit
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= iet_pkg::MAX_FRAME_BYTES)
		else $error("byte position beyond frame limit");
`endif

endmodule

/* test/deframer_checker.sv */
`timescale 1ns / 100ps

module deframer_checker
	import iet_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [7:0]             s_axis_tdata,   // data_byte
	input  logic                   s_axis_tlast,   // last_byte
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// payload_byte[7:0], verdict[10:8], session_id[74:11], source_addr[106:75],
	// payload_len[122:107], peer_updated[123], zero[127:124]
	input  logic [127:0]           m_axis_tdata,
	input  logic                   m_axis_tuser,   // byte_valid
	input  logic                   m_axis_tlast,   // frame_end
	output int                     outstanding,
	output int                     error_count
);

	typedef struct {
		result_t fields;
		logic    byte_valid;
		logic    frame_end;
	} deframe_result_t;

	// Register copies
	logic        mode_server;
	logic [15:0] ident_cfg;
	logic [15:0] cap_cfg;

	// Per-frame parse state
	logic [15:0] frame_pos;
	logic [5:0]  ihl_bytes;
	logic [2:0]  first_fault;
	logic [7:0]  ident_high;
	logic [63:0] sid_acc;
	logic [31:0] src_acc;

	// Learned peer, kept across frames
	logic        peer_held;
	logic [31:0] peer_addr;

	deframe_result_t expected_results[$];
	deframe_result_t oldest;
	deframe_result_t fresh;
	result_t         seen;
	int              fail_total = 0;

	assign error_count = fail_total;

	function automatic void clear_frame();
		frame_pos   = '0;
		ihl_bytes   = '0;
		first_fault = VERDICT_ACCEPT;
		ident_high  = '0;
		sid_acc     = '0;
		src_acc     = '0;
	endfunction

	// Advance the parse by one frame byte; return 1 when the byte yields a result
	function automatic bit predict_frame_byte(input logic [7:0] b, input logic closes,
			output deframe_result_t entry);
		int unsigned p;
		int unsigned h;
		int unsigned rel;
		int unsigned n;
		int unsigned plen;
		logic        pass;
		logic [2:0]  verdict;
		p    = 32'(frame_pos);
		pass = 1'b0;
		plen = 0;
		entry.fields     = '0;
		entry.byte_valid = 1'b0;
		entry.frame_end  = 1'b0;

		if (p >= MAX_FRAME_BYTES) begin
			first_fault = VERDICT_MALFORMED;
		end else begin
			if (p == 0) begin
				ihl_bytes = {b[3:0], 2'b00};
				if (b[7:4] != IP_VERSION || {b[3:0], 2'b00} < IP_MIN_HDR)
					first_fault = VERDICT_MALFORMED;
			end
			if (p >= POS_SRC_FIRST && p <= POS_SRC_LAST)
				src_acc = {src_acc[23:0], b};
			if (first_fault == VERDICT_ACCEPT) begin
				h = 32'(ihl_bytes);
				if (p == POS_PROTOCOL && b != PROTO_ICMP) begin
					first_fault = VERDICT_NOT_ICMP;
				end else if (p >= h && h >= IP_MIN_HDR) begin
					rel = p - h;
					if (rel == REL_TYPE) begin
						if (!(b == TYPE_REQUEST || (!mode_server && b == TYPE_REPLY)))
							first_fault = VERDICT_WRONG_TYPE;
					end else if (rel == REL_ID_HIGH) begin
						ident_high = b;
					end else if (rel == REL_ID_LOW) begin
						if ({ident_high, b} != ident_cfg)
							first_fault = VERDICT_WRONG_ID;
					end else if (rel >= ICMP_LEN && rel < PAYLOAD_START) begin
						sid_acc = {sid_acc[55:0], b};
					end else if (rel >= PAYLOAD_START) begin
						pass = (rel - PAYLOAD_START) < cap_cfg;
					end
				end
			end
			frame_pos = 16'(p + 1);
		end

		if (!pass && !closes)
			return 1'b0;

		entry.byte_valid          = pass;
		entry.fields.payload_byte = pass ? b : 8'd0;

		// Frame verdict on the last byte; short frames override any other reason
		if (closes) begin
			n = p + 1;
			h = 32'(ihl_bytes);
			if (first_fault == VERDICT_MALFORMED || n < IP_MIN_HDR || n < h + PAYLOAD_START) begin
				verdict = VERDICT_MALFORMED;
			end else if (first_fault != VERDICT_ACCEPT) begin
				verdict = first_fault;
			end else begin
				plen    = n - h - PAYLOAD_START;
				verdict = (plen > cap_cfg) ? VERDICT_TOO_LONG : VERDICT_ACCEPT;
			end
			entry.frame_end      = 1'b1;
			entry.fields.verdict = verdict;
			if (verdict == VERDICT_ACCEPT) begin
				entry.fields.session_id  = sid_acc;
				entry.fields.source_addr = src_acc;
				entry.fields.payload_len = plen[15:0];
				if (mode_server && (!peer_held || peer_addr != src_acc)) begin
					peer_held                 = 1'b1;
					peer_addr                 = src_acc;
					entry.fields.peer_updated = 1'b1;
				end
			end
			clear_frame();
		end
		return 1'b1;
	endfunction

	task automatic check_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
			fail_total++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_server = 1'b0;
			ident_cfg   = '0;
			cap_cfg     = 16'hFFFF;
			peer_held   = 1'b0;
			peer_addr   = '0;
			clear_frame();
			expected_results.delete();
			outstanding <= 0;
		end else begin
			// Compare a delivered result against the oldest prediction
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					$error("result item 0x%0h with no prediction pending", m_axis_tdata);
					fail_total++;
				end else begin
					oldest = expected_results.pop_front();
					seen   = result_t'(m_axis_tdata);
					check_field("byte_valid", 64'(oldest.byte_valid), 64'(m_axis_tuser));
					check_field("frame_end", 64'(oldest.frame_end), 64'(m_axis_tlast));
					check_field("payload_byte", 64'(oldest.fields.payload_byte),
						64'(seen.payload_byte));
					check_field("verdict", 64'(oldest.fields.verdict), 64'(seen.verdict));
					check_field("session_id", oldest.fields.session_id, seen.session_id);
					check_field("source_addr", 64'(oldest.fields.source_addr),
						64'(seen.source_addr));
					check_field("payload_len", 64'(oldest.fields.payload_len),
						64'(seen.payload_len));
					check_field("peer_updated", 64'(oldest.fields.peer_updated),
						64'(seen.peer_updated));
				end
			end

			// Track register writes
			if (cfg_we) begin
				case (cfg_index)
					REG_SERVER_MODE: mode_server = cfg_data[0];
					REG_TUNNEL_ID:   ident_cfg   = cfg_data;
					REG_PAYLOAD_CAP: cap_cfg     = cfg_data;
					default: ;
				endcase
			end

			// Predict the result of an accepted frame byte
			if (s_axis_tvalid && s_axis_tready) begin
				if (predict_frame_byte(s_axis_tdata, s_axis_tlast, fresh))
					expected_results.push_back(fresh);
			end

			outstanding <= expected_results.size();
		end
	end

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;
	import iet_pkg::*;

	typedef logic [7:0] octet_q_t[$];

	localparam int STALL_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASE_OCTETS = 290;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   cfg_we        = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index     = '0;
	logic [CFG_DATA_W-1:0]  cfg_data      = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [7:0]             s_axis_tdata  = '0;
	logic                   s_axis_tlast  = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [127:0]           m_axis_tdata;
	logic                   m_axis_tuser;
	logic                   m_axis_tlast;

	int          outstanding;
	int          error_count;
	int          stall_cycles  = 0;
	int          sent_in_phase = 0;
	bit          idle_enable   = 1'b1;
	bit          hold_pending  = 1'b0;
	logic [31:0] src_pool[3];

	icmp_echo_tunnel_deframer_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	deframer_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.outstanding   (outstanding),
		.error_count   (error_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// End the run if nothing moves on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Result sink: random back-pressure bursts, one long hold-off on request
	initial begin
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_pending) begin
				hold_pending = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (idle_enable && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// Offer one frame byte, with an occasional idle burst ahead of it
	task automatic send_byte(input logic [7:0] b, input logic closes);
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= closes;
		do @(posedge clk); while (!s_axis_tready);
		sent_in_phase++;
	endtask

	task automatic send_run(input octet_q_t octets, input bit closes);
		foreach (octets[i])
			send_byte(octets[i], closes && (i == octets.size() - 1));
	endtask

	// Drain, then rewrite all three registers
	task automatic set_config(input logic mode, input logic [15:0] ident,
			input logic [15:0] cap);
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_SERVER_MODE;
		cfg_data  <= {15'd0, mode};
		@(posedge clk);
		cfg_index <= REG_TUNNEL_ID;
		cfg_data  <= ident;
		@(posedge clk);
		cfg_index <= REG_PAYLOAD_CAP;
		cfg_data  <= cap;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Assemble an IPv4 frame carrying an ICMP echo with session id and payload
	function automatic octet_q_t build_echo(input logic [3:0] ihl, input logic [7:0] proto,
			input logic [7:0] icmp_type, input logic [15:0] ident, input logic [63:0] sid,
			input logic [31:0] src, input int unsigned plen);
		octet_q_t    q;
		int unsigned hlen;
		hlen = ihl * 4;
		q.push_back({IP_VERSION, ihl});
		for (int i = 1; i < hlen; i++) q.push_back(8'($urandom_range(0, 255)));
		q[POS_PROTOCOL] = proto;
		for (int i = 0; i < 4; i++) q[POS_SRC_FIRST + i] = src[31 - 8 * i -: 8];
		q.push_back(icmp_type);
		repeat (3) q.push_back(8'($urandom_range(0, 255)));
		q.push_back(ident[15:8]);
		q.push_back(ident[7:0]);
		repeat (2) q.push_back(8'($urandom_range(0, 255)));
		for (int i = 0; i < 8; i++) q.push_back(sid[63 - 8 * i -: 8]);
		repeat (plen) q.push_back(8'($urandom_range(0, 255)));
		return q;
	endfunction

	// Send the head of a frame, change the mode while idle, then finish the frame
	task automatic send_split(input octet_q_t f, input int cut, input logic mode_after,
			input logic [15:0] ident, input logic [15:0] cap);
		octet_q_t head_part;
		octet_q_t tail_part;
		foreach (f[i]) begin
			if (i < cut) head_part.push_back(f[i]);
			else tail_part.push_back(f[i]);
		end
		send_run(head_part, 1'b0);
		set_config(mode_after, ident, cap);
		send_run(tail_part, 1'b1);
	endtask

	// Mostly well-formed echoes with random content, some truncated or garbage
	task automatic send_random_frame(input logic [15:0] ident);
		octet_q_t    q;
		int          kind;
		int          pick;
		int          cut;
		logic [3:0]  ihl;
		logic [7:0]  ty;
		logic [7:0]  proto;
		logic [15:0] id_sent;
		logic [31:0] src;
		int unsigned plen;
		kind  = $urandom_range(0, 99);
		ihl   = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 15)) : 4'd5;
		pick  = $urandom_range(0, 9);
		ty    = (pick < 7) ? TYPE_REQUEST : (pick < 9) ? TYPE_REPLY : 8'($urandom_range(0, 255));
		proto = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : PROTO_ICMP;
		id_sent = ($urandom_range(0, 6) == 0) ? 16'($urandom_range(0, 65535)) : ident;
		plen  = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 24);
		src   = ($urandom_range(0, 1) == 1) ? src_pool[$urandom_range(0, 2)] : $urandom;
		q = build_echo(ihl, proto, ty, id_sent, {$urandom, $urandom}, src, plen);
		if (kind >= 65 && kind < 80) begin
			cut = $urandom_range(1, q.size() - 1);
			while (q.size() > cut) void'(q.pop_back());
		end else if (kind >= 80 && kind < 90) begin
			q[0] = 8'($urandom_range(0, 255));
		end else if (kind >= 90) begin
			q.delete();
			repeat ($urandom_range(1, 60)) q.push_back(8'($urandom_range(0, 255)));
		end
		send_run(q, 1'b1);
	endtask

	initial begin
		octet_q_t    f;
		logic [15:0] ident;
		foreach (src_pool[i]) src_pool[i] = $urandom;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Client mode: every verdict but too-long, and the header corner cases
		set_config(1'b0, 16'h1234, 16'hFFFF);
		send_run(build_echo(4'd5, PROTO_ICMP, TYPE_REQUEST, 16'h1234, 64'd0, 32'd0, 0), 1'b1);
		send_run(build_echo(4'd5, PROTO_ICMP, TYPE_REPLY, 16'h1234, '1, '1, 3), 1'b1);
		send_run(build_echo(4'd5, PROTO_ICMP, TYPE_REQUEST, 16'h1235, '1, 32'h0A000001, 2),
			1'b1);
		send_run(build_echo(4'd5, 8'd6, TYPE_REQUEST, 16'h1234, 64'd7, 32'h0A000002, 1), 1'b1);
		send_run(build_echo(4'd5, PROTO_ICMP, 8'd3, 16'h1234, 64'd9, 32'h0A000003, 1), 1'b1);
		f = build_echo(4'd5, PROTO_ICMP, TYPE_REQUEST, 16'h1234, 64'd1, 32'h0A000004, 2);
		f[0] = 8'h65;
		send_run(f, 1'b1);
		f[0] = 8'h44;
		send_run(f, 1'b1);
		send_run(build_echo(4'd15, PROTO_ICMP, TYPE_REQUEST, 16'h1234, 64'h0123456789ABCDEF,
			32'hC0A80101, 2), 1'b1);
		// Short frames, including one whose identifier is also wrong
		f = build_echo(4'd5, PROTO_ICMP, TYPE_REQUEST, 16'h1234, 64'd2, 32'h0A000005, 4);
		while (f.size() > 10) void'(f.pop_back());
		send_run(f, 1'b1);
		f = build_echo(4'd5, PROTO_ICMP, TYPE_REQUEST, 16'hBEEF, 64'd3, 32'h0A000006, 4);
		while (f.size() > 30) void'(f.pop_back());
		send_run(f, 1'b1);
		send_byte(8'h45, 1'b1);

		// Server mode: learning, replies refused, capacity overflow
		set_config(1'b1, 16'hFFFF, 16'd4);
		send_run(build_echo(4'd5, PROTO_ICMP, TYPE_REQUEST, 16'hFFFF, 64'd10, 32'hC0A80001, 4),
			1'b1);
		send_run(build_echo(4'd5, PROTO_ICMP, TYPE_REQUEST, 16'hFFFF, 64'd11, 32'hC0A80001, 1),
			1'b1);
		send_run(build_echo(4'd5, PROTO_ICMP, TYPE_REQUEST, 16'hFFFF, 64'd12, 32'hC0A80002, 0),
			1'b1);
		send_run(build_echo(4'd5, PROTO_ICMP, TYPE_REPLY, 16'hFFFF, 64'd13, 32'hC0A80003, 2),
			1'b1);
		send_run(build_echo(4'd5, PROTO_ICMP, TYPE_REQUEST, 16'hFFFF, 64'd14, 32'hC0A80004, 5),
			1'b1);

		// Mode flips mid-frame: type uses the mode at the type byte, learning the last byte
		send_split(build_echo(4'd5, PROTO_ICMP, TYPE_REPLY, 16'hFFFF, 64'd15, 32'hC0A80005, 3),
			20, 1'b0, 16'hFFFF, 16'd4);
		send_split(build_echo(4'd5, PROTO_ICMP, TYPE_REQUEST, 16'hFFFF, 64'd16, 32'hC0A80006, 2),
			21, 1'b1, 16'hFFFF, 16'd4);

		// Zero capacity
		set_config(1'b0, 16'h0000, 16'd0);
		send_run(build_echo(4'd5, PROTO_ICMP, TYPE_REQUEST, 16'h0000, 64'd17, 32'h01020304, 0),
			1'b1);
		send_run(build_echo(4'd5, PROTO_ICMP, TYPE_REQUEST, 16'h0000, 64'd18, 32'h01020304, 3),
			1'b1);

		// Frame running past the largest allowed length
		set_config(1'b0, 16'h5A5A, 16'hFFFF);
		send_run(build_echo(4'd5, PROTO_ICMP, TYPE_REQUEST, 16'h5A5A, 64'd19, 32'h05060708,
			MAX_FRAME_BYTES + 2 - 36), 1'b1);

		// Random phases across register settings
		for (int ph = 0; ph < 6; ph++) begin
			ident = 16'($urandom_range(0, 65535));
			case (ph)
				0: set_config(1'b0, ident, 16'hFFFF);
				1: set_config(1'b1, ident, 16'hFFFF);
				2: begin
					ident = 16'h0000;
					set_config(1'b1, ident, 16'($urandom_range(0, 30)));
				end
				3: begin
					ident = 16'hFFFF;
					set_config(1'b0, ident, 16'd0);
				end
				4: begin
					ident = 16'hFFFF;
					set_config(1'b1, ident, 16'($urandom_range(8, 24)));
				end
				default: set_config(1'b0, ident, 16'hFFFF);
			endcase
			if (ph == 1) hold_pending = 1'b1;
			if (ph == 5) idle_enable = 1'b0;
			sent_in_phase = 0;
			while (sent_in_phase < PHASE_OCTETS) send_random_frame(ident);
		end

		// Drain and report
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* icmp_echo_tunnel_deframer_unit.f */
design/iet_pkg.sv
design/icmp_echo_tunnel_deframer_unit.sv
test/deframer_checker.sv
test/testbench.sv
